// ===== hw/rtl/centroid_similarity_scorer_core_defines.svh =====
// Assertion helpers used by the checker file csim_checker.sv.
`ifndef CENTROID_SIMILARITY_SCORER_CORE_DEFINES_SVH
`define CENTROID_SIMILARITY_SCORER_CORE_DEFINES_SVH

// Property checked only outside reset.
`define CSIM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CSIM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/csim_pkg.sv =====
`default_nettype none

package csim_pkg;

  localparam int ELEMENT_BITS   = 16;
  localparam int SCORE_BITS     = 48;
  localparam int ROW_BITS       = 12;
  localparam int DIM_BITS       = 11;
  localparam int ROWS_BITS      = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;

  localparam int MAX_DIM_DEFAULT  = 1024;
  localparam int MAX_ROWS_DEFAULT = 4096;
  localparam int QUEUE_DEPTH      = 4;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIMENSION      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTROID_COUNT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_METRIC_MODE    = 2'd2;

  localparam logic MODE_DOT  = 1'b0;
  localparam logic MODE_DIST = 1'b1;

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CENTROID = 1'b1;

  typedef struct packed {
    logic                           func;
    logic signed [ELEMENT_BITS-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic [ROW_BITS-1:0]          row_index;
    logic [ROW_BITS-1:0]          best_index;
    logic signed [SCORE_BITS-1:0] top_score;
    logic                         last_row;
  } out_item_t;

  // one centroid element paired with its query element
  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] query;
    logic signed [ELEMENT_BITS-1:0] element;
    logic                           row_end;
  } work_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csim_front.sv =====
`default_nettype none

module csim_front #(
  parameter int MAX_DIM = csim_pkg::MAX_DIM_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire csim_pkg::in_item_t        in_item,
  input  wire [csim_pkg::DIM_BITS-1:0]   dimension,
  input  wire                            room,
  output logic                           push_valid,
  output csim_pkg::work_t                push_entry
);

  localparam int PW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIMW = csim_pkg::DIM_BITS;
  localparam int DCW  = (PW + 1 > DIMW) ? PW + 1 : DIMW;
  localparam int EB   = csim_pkg::ELEMENT_BITS;

  logic signed [EB-1:0] query_mem [MAX_DIM];

  logic [PW-1:0]        load_ptr;
  logic [PW-1:0]        elem_ptr;
  logic [DCW-1:0]       load_inc;
  logic [DCW-1:0]       elem_inc;
  logic                 load_wrap;
  logic                 elem_wrap;
  logic                 accept;
  logic                 take_load;
  logic                 take_elem;

  logic signed [EB-1:0] rd_query;
  logic signed [EB-1:0] s1_elem;
  logic                 s1_end;
  logic                 s1_valid;

  assign in_ready  = room;
  assign accept    = in_valid && in_ready;
  assign take_load = accept && (in_item.func == csim_pkg::FUNC_LOAD);
  assign take_elem = accept && (in_item.func == csim_pkg::FUNC_CENTROID);

  assign load_inc  = DCW'(load_ptr) + DCW'(1);
  assign elem_inc  = DCW'(elem_ptr) + DCW'(1);
  assign load_wrap = load_inc >= DCW'(dimension);
  assign elem_wrap = elem_inc >= DCW'(dimension);

  always_ff @(posedge clk) begin
    if (take_load) begin
      query_mem[load_ptr] <= in_item.element;
    end
  end

  // registered read; a load taken in the cycle before is already visible
  always_ff @(posedge clk) begin
    if (take_elem) begin
      rd_query <= query_mem[elem_ptr];
      s1_elem  <= in_item.element;
      s1_end   <= elem_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr <= '0;
      elem_ptr <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take_elem;
      if (take_load) begin
        load_ptr <= load_wrap ? '0 : PW'(load_inc);
      end
      if (take_elem) begin
        elem_ptr <= elem_wrap ? '0 : PW'(elem_inc);
      end
    end
  end

  assign push_valid         = s1_valid;
  assign push_entry.query   = rd_query;
  assign push_entry.element = s1_elem;
  assign push_entry.row_end = s1_end;

endmodule

`default_nettype wire

// ===== hw/rtl/csim_queue.sv =====
`default_nettype none

module csim_queue #(
  parameter int DEPTH = csim_pkg::QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push_valid,
  input  wire csim_pkg::work_t  push_entry,
  output logic                  room,
  output logic                  pop_valid,
  input  wire                   pop_ready,
  output csim_pkg::work_t       pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csim_pkg::work_t slots [DEPTH];

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push      = push_valid && (count < CW'(DEPTH));
  assign pop       = pop_valid && pop_ready;
  assign pop_valid = count != '0;
  assign pop_entry = slots[rd_ptr];
  // keep one slot for the item still in the front's read stage
  assign room      = count <= CW'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csim_back.sv =====
`default_nettype none

module csim_back #(
  parameter int MAX_ROWS = csim_pkg::MAX_ROWS_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             metric_mode,
  input  wire [csim_pkg::ROWS_BITS-1:0]   centroid_count,
  input  wire                             pop_valid,
  output logic                            pop_ready,
  input  wire csim_pkg::work_t            pop_entry,
  output logic                            out_valid,
  input  wire                             out_ready,
  output csim_pkg::out_item_t             out_item
);

  localparam int EB   = csim_pkg::ELEMENT_BITS;
  localparam int MW   = EB + 1;
  localparam int TW   = 2 * MW;
  localparam int SW   = csim_pkg::SCORE_BITS;
  localparam int RB   = csim_pkg::ROW_BITS;
  localparam int RSB  = csim_pkg::ROWS_BITS;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW  = (RW + 1 > RSB) ? RW + 1 : RSB;

  logic                 adv;

  logic signed [MW-1:0] q_ext;
  logic signed [MW-1:0] e_ext;
  logic signed [MW-1:0] diff;
  logic signed [MW-1:0] ma;
  logic signed [MW-1:0] mb;
  logic signed [TW-1:0] prod;

  logic                 a_valid;
  logic                 a_end;
  logic signed [TW-1:0] a_term;

  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] acc_sum;
  logic                 b_valid;
  logic signed [SW-1:0] b_sum;

  logic [RW-1:0]        row;
  logic [RCW-1:0]       row_inc;
  logic                 pass_end;
  logic signed [SW-1:0] best_value;
  logic [RW-1:0]        best_row;
  logic signed [SW-1:0] score;
  logic                 take;

  // the whole back pipe moves when the output register can load
  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;

  always_comb begin
    q_ext = MW'(pop_entry.query);
    e_ext = MW'(pop_entry.element);
    diff  = q_ext - e_ext;
    if (metric_mode == csim_pkg::MODE_DIST) begin
      ma = diff;
      mb = diff;
    end else begin
      ma = q_ext;
      mb = e_ext;
    end
    prod = ma * mb;
  end

  assign acc_sum = acc + SW'(a_term);

  assign score    = (metric_mode == csim_pkg::MODE_DIST) ? -b_sum : b_sum;
  assign take     = (row == '0) || (score > best_value);
  assign row_inc  = RCW'(row) + RCW'(1);
  assign pass_end = row_inc >= RCW'(centroid_count);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_term <= prod;
      a_end  <= pop_entry.row_end;
      b_sum  <= acc_sum;
      if (b_valid) begin
        out_item.score      <= score;
        out_item.row_index  <= RB'(row);
        out_item.best_index <= take ? RB'(row) : RB'(best_row);
        out_item.top_score  <= take ? score : best_value;
        out_item.last_row   <= pass_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      out_valid  <= 1'b0;
      acc        <= '0;
      row        <= '0;
      best_value <= '0;
      best_row   <= '0;
    end else if (adv) begin
      a_valid   <= pop_valid;
      b_valid   <= a_valid && a_end;
      out_valid <= b_valid;
      if (a_valid) begin
        acc <= a_end ? '0 : acc_sum;
      end
      if (b_valid) begin
        if (take) begin
          best_value <= score;
          best_row   <= row;
        end
        row <= pass_end ? '0 : RW'(row_inc);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/centroid_similarity_scorer_core.sv =====
// Channel | Dir | Handshake              | Payload
// in      | in  | in_valid / in_ready    | in_item: func, element (Q4.12)
// out     | out | out_valid / out_ready  | out_item: score, row_index, best_index,
//         |     |                        |           top_score, last_row
// cfg     | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// Sustains one item per cycle; once a row's last element is taken, its result
// passes the query memory read, a queue slot, the product stage, the
// accumulate stage, then the score/best output register to out_valid.
// The single multiply-accumulate unit sets the rate; in_ready drops only when
// the front-to-back queue is near full.
// A stalled output freezes the back pipe only; the front keeps taking items
// until the queue fills. Sync reset clears pointers, counters, best and valids;
// the query memory has no reset and needs no clearing pass.
`default_nettype none

module centroid_similarity_scorer_core #(
  parameter int MAX_DIM  = csim_pkg::MAX_DIM_DEFAULT,
  parameter int MAX_ROWS = csim_pkg::MAX_ROWS_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire csim_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output csim_pkg::out_item_t                  out_item,
  input  wire                                  cfg_we,
  input  wire [csim_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [csim_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int DIMW = csim_pkg::DIM_BITS;
  localparam int RSB  = csim_pkg::ROWS_BITS;

  // config registers hold the clamped (effective) values
  logic [DIMW-1:0] dimension;
  logic [RSB-1:0]  centroid_count;
  logic            metric_mode;

  logic [DIMW-1:0] dim_wr;
  logic [RSB-1:0]  rows_wr;

  logic            fq_valid;
  csim_pkg::work_t fq_entry;
  logic            q_room;
  logic            qb_valid;
  logic            qb_ready;
  csim_pkg::work_t qb_entry;

  assign dim_wr  = cfg_data[DIMW-1:0];
  assign rows_wr = cfg_data[RSB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension      <= DIMW'(1);
      centroid_count <= RSB'(1);
      metric_mode    <= csim_pkg::MODE_DIST;
    end else if (cfg_we) begin
      case (cfg_index)
        csim_pkg::REG_DIMENSION: begin
          if (dim_wr == '0) begin
            dimension <= DIMW'(1);
          end else if (32'(dim_wr) > MAX_DIM) begin
            dimension <= DIMW'(MAX_DIM);
          end else begin
            dimension <= dim_wr;
          end
        end
        csim_pkg::REG_CENTROID_COUNT: begin
          if (rows_wr == '0) begin
            centroid_count <= RSB'(1);
          end else if (32'(rows_wr) > MAX_ROWS) begin
            centroid_count <= RSB'(MAX_ROWS);
          end else begin
            centroid_count <= rows_wr;
          end
        end
        csim_pkg::REG_METRIC_MODE: begin
          metric_mode <= cfg_data[0];
        end
        default: begin
          // unused index: ignored
        end
      endcase
    end
  end

  // front: query loads and pointer tracking, pairs each centroid element
  // with its query element
  csim_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .dimension  (dimension),
    .room       (q_room),
    .push_valid (fq_valid),
    .push_entry (fq_entry)
  );

  csim_queue #(
    .DEPTH (csim_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_entry (fq_entry),
    .room       (q_room),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_entry  (qb_entry)
  );

  // back: multiply, accumulate, score and running best
  csim_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .metric_mode    (metric_mode),
    .centroid_count (centroid_count),
    .pop_valid      (qb_valid),
    .pop_ready      (qb_ready),
    .pop_entry      (qb_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/csim_checker.sv =====
`default_nettype none
`include "centroid_similarity_scorer_core_defines.svh"

module csim_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire csim_pkg::out_item_t  out_item
);

  logic stalled;
  logic first_row;
  logic top_ok;
  logic first_ok;

  assign stalled   = out_valid && !out_ready;
  assign first_row = out_valid && (out_item.row_index == '0);
  assign top_ok    = out_item.top_score >= out_item.score;
  assign first_ok  = (out_item.best_index == '0) && (out_item.top_score == out_item.score);

  `CSIM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid right after reset")
  `CSIM_ASSERT(a_out_hold, clk, rst, stalled |=> out_valid && $stable(out_item), "item changed")
  `CSIM_ASSERT(a_best_ge, clk, rst, out_valid |-> top_ok, "best below current score")
  `CSIM_ASSERT(a_first_row, clk, rst, first_row |-> first_ok, "first row did not set best")

endmodule

bind centroid_similarity_scorer_core csim_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ===== tb/centroid_score_checker.sv =====
module centroid_score_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  csim_pkg::in_item_t                  in_item,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  csim_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [csim_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [csim_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  errors,
  output int                                  pending
);
  import csim_pkg::*;

  localparam int QW = $clog2(MAX_DIM_DEFAULT);
  localparam int DW = ELEMENT_BITS + 1;

  logic signed [ELEMENT_BITS-1:0] query_mem [0:MAX_DIM_DEFAULT-1];
  int                             load_ptr;
  int                             elem_ptr;
  int                             row_num;
  int                             best_row;
  logic signed [SCORE_BITS-1:0]   acc;
  logic signed [SCORE_BITS-1:0]   best_val;
  logic [DIM_BITS-1:0]            dim_reg;
  logic [ROWS_BITS-1:0]           rows_reg;
  logic                           mode_reg;

  out_item_t expected_rows[$];
  int        fail_count = 0;
  int        row_backlog = 0;

  assign errors  = fail_count;
  assign pending = row_backlog;

  function automatic int dim_limit();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return int'(dim_reg);
  endfunction

  function automatic int rows_limit();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS_DEFAULT) return MAX_ROWS_DEFAULT;
    return int'(rows_reg);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // one accepted item: a query load, or one centroid element (maybe ending a row)
  task automatic take_element(input in_item_t it);
    logic signed [ELEMENT_BITS-1:0] e;
    logic signed [DW-1:0]           diff;
    logic signed [SCORE_BITS-1:0]   term;
    logic signed [SCORE_BITS-1:0]   score;
    out_item_t                      row;
    e = it.element;
    if (it.func == FUNC_LOAD) begin
      query_mem[QW'(load_ptr)] = e;
      load_ptr = (load_ptr + 1 >= dim_limit()) ? 0 : load_ptr + 1;
    end else begin
      if (mode_reg == MODE_DOT) begin
        term = SCORE_BITS'(query_mem[QW'(elem_ptr)]) * SCORE_BITS'(e);
      end else begin
        diff = DW'(query_mem[QW'(elem_ptr)]) - DW'(e);
        term = SCORE_BITS'(diff) * SCORE_BITS'(diff);
      end
      acc = acc + term;
      if (elem_ptr + 1 < dim_limit()) begin
        elem_ptr++;
      end else begin
        elem_ptr = 0;
        score = (mode_reg == MODE_DOT) ? acc : -acc;
        acc = '0;
        // first row of a pass always wins; ties keep the earlier row
        if (row_num == 0 || score > best_val) begin
          best_val = score;
          best_row = row_num;
        end
        row.score      = score;
        row.row_index  = ROW_BITS'(row_num);
        row.best_index = ROW_BITS'(best_row);
        row.top_score  = best_val;
        row.last_row   = (row_num + 1 >= rows_limit());
        expected_rows.push_back(row);
        row_num = row.last_row ? 0 : row_num + 1;
      end
    end
  endtask

  task automatic check_row(input out_item_t got);
    out_item_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch("result with no row pending", 64'(got.row_index), 64'(0));
    end else begin
      want = expected_rows.pop_front();
      if (got.score !== want.score)
        report_mismatch("score", 64'(got.score), 64'(want.score));
      if (got.row_index !== want.row_index)
        report_mismatch("row_index", 64'(got.row_index), 64'(want.row_index));
      if (got.best_index !== want.best_index)
        report_mismatch("best_index", 64'(got.best_index), 64'(want.best_index));
      if (got.top_score !== want.top_score)
        report_mismatch("top_score", 64'(got.top_score), 64'(want.top_score));
      if (got.last_row !== want.last_row)
        report_mismatch("last_row", 64'(got.last_row), 64'(want.last_row));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      load_ptr = 0;
      elem_ptr = 0;
      row_num  = 0;
      best_row = 0;
      acc      = '0;
      best_val = '0;
      dim_reg  = DIM_BITS'(1);
      rows_reg = ROWS_BITS'(1);
      mode_reg = MODE_DIST;
      expected_rows.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIMENSION:      dim_reg  = cfg_data[DIM_BITS-1:0];
          REG_CENTROID_COUNT: rows_reg = cfg_data[ROWS_BITS-1:0];
          REG_METRIC_MODE:    mode_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_element(in_item);
      if (out_valid && out_ready) check_row(out_item);
    end
    row_backlog = expected_rows.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import csim_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int errors;
  int pending;

  // idling knobs, percent of cycles
  int send_gap_pct  = 0;
  int stall_pct     = 0;
  // each bump asks the receiver for one long hold-off
  int hold_requests = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  centroid_similarity_scorer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  centroid_score_checker score_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // Receiver: random stalls, plus a long hold-off when asked. The hold-off is
  // counted here so the sender can keep pushing items into a backed-up block.
  initial begin : receiver
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served    = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Mostly fixed values (the edges of Q4.12, zero and +/-1 LSB), otherwise random.
  function automatic logic signed [ELEMENT_BITS-1:0] pick_element();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      4: return 16'sd1;
      default: return ELEMENT_BITS'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is
  // taken. Valid stays up between back-to-back items, so it is never dropped
  // and raised within one step.
  task automatic offer_item(input logic func, input logic signed [ELEMENT_BITS-1:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_item.func    <= func;
    in_item.element <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop sending and wait for every predicted row; then give in-flight
  // elements that end no row time to clear the front, the queue and the back pipe.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // All three registers back to back; write enable drops once at the end.
  task automatic program_regs(input int dim, input int rows, input logic mode);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DIMENSION;
    cfg_data  <= CFG_DATA_BITS'(dim);
    @(negedge clk);
    cfg_index <= REG_CENTROID_COUNT;
    cfg_data  <= CFG_DATA_BITS'(rows);
    @(negedge clk);
    cfg_index <= REG_METRIC_MODE;
    cfg_data  <= CFG_DATA_BITS'(mode);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_query(input int n);
    repeat (n) offer_item(FUNC_LOAD, pick_element());
  endtask

  task automatic stream_centroid(input int n);
    repeat (n) offer_item(FUNC_CENTROID, pick_element());
  endtask

  // Reconfigure, reload a full query, then a random stream: mostly centroid
  // elements, with stray query loads landing mid-row.
  task automatic random_pass(input int dim, input int rows, input logic mode,
                             input int n, input int gap, input int stall);
    settle();
    program_regs(dim, rows, mode);
    send_gap_pct = gap;
    stall_pct    = stall;
    load_query(dim);
    repeat (n) begin
      if ($urandom_range(99) < 15) offer_item(FUNC_LOAD, pick_element());
      else offer_item(FUNC_CENTROID, pick_element());
    end
  endtask

  initial begin : stimulus
    int dim;
    int rows;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: dimension 1, one row per pass, squared L2. Largest
    // differences both ways, and zero distance.
    offer_item(FUNC_LOAD,     16'sh7fff);
    offer_item(FUNC_CENTROID, 16'sh8000);
    offer_item(FUNC_CENTROID, 16'sh7fff);
    offer_item(FUNC_LOAD,     16'sh8000);
    offer_item(FUNC_CENTROID, 16'sh8000);
    offer_item(FUNC_CENTROID, 16'sh7fff);

    // Zero dimension and zero row count both behave as one; dot mode extremes.
    settle();
    program_regs(0, 0, MODE_DOT);
    offer_item(FUNC_LOAD,     16'sh8000);
    offer_item(FUNC_CENTROID, 16'sh8000);
    offer_item(FUNC_CENTROID, 16'sh7fff);
    offer_item(FUNC_LOAD,     16'sh7fff);
    offer_item(FUNC_CENTROID, 16'sh7fff);

    // Best tracking: a negative first row still takes the best, a greater
    // score replaces it, a tie keeps the older row; the next pass starts over.
    settle();
    program_regs(1, 3, MODE_DOT);
    offer_item(FUNC_LOAD,     16'sd1);
    offer_item(FUNC_CENTROID, -16'sd5);
    offer_item(FUNC_CENTROID, -16'sd3);
    offer_item(FUNC_CENTROID, -16'sd3);
    offer_item(FUNC_CENTROID, 16'sd4);
    offer_item(FUNC_CENTROID, 16'sd4);

    // Query reload in the middle of a row affects only later elements.
    settle();
    program_regs(2, 2, MODE_DIST);
    offer_item(FUNC_LOAD,     16'sd100);
    offer_item(FUNC_LOAD,     -16'sd200);
    offer_item(FUNC_CENTROID, 16'sd7);
    offer_item(FUNC_LOAD,     16'sh7fff);
    offer_item(FUNC_CENTROID, 16'sh8000);

    // Oversized sizes: dimension 2047 acts as 1024 and row count 8191 as
    // 4096, so 40 elements end no row. Shrinking the dimension then ends the
    // open row on the next element. These loads start at entry 1, where the last test
    // left the load pointer; with entry 0 loaded earlier, every entry the later sizes read is set.
    settle();
    program_regs(2047, 8191, MODE_DIST);
    load_query(48);
    stream_centroid(40);
    settle();
    program_regs(3, 8191, MODE_DIST);
    stream_centroid(8);

    // Back-pressure: the receiver holds off while the sender keeps going, so
    // the internal queue fills and input ready drops. The row counter sits on the
    // last row of the new count, so the first row ends the pass. The next settle makes
    // the sender wait for every pending row.
    settle();
    program_regs(1, 4, MODE_DOT);
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_requests++;
    stream_centroid(60);

    // Random passes, cycling through the idling profiles. Row count 4096 is
    // left unfinished so the next, smaller count cuts the pass short.
    for (int p = 0; p < 8; p++) begin
      dim  = (p == 3) ? 16 : $urandom_range(1, 8);
      rows = (p == 5) ? MAX_ROWS_DEFAULT : (p == 6) ? 0 : $urandom_range(1, 5);
      case (p % 4)
        0: random_pass(dim, rows, 1'($urandom_range(1)), 55, 0, 0);
        1: random_pass(dim, rows, 1'($urandom_range(1)), 55, 70, 0);
        2: random_pass(dim, rows, 1'($urandom_range(1)), 55, 0, 70);
        default: random_pass(dim, rows, 1'($urandom_range(1)), 55, 37, 37);
      endcase
    end

    settle();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
